@@ hdl/brtn_pkg.sv @@
// Shared codes and types of the bracket record tree navigator.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package brtn_pkg;

  localparam int INDEX_W = 10;
  localparam int NAV_W   = 11;
  localparam int WORD_W  = 32;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_MODIFY = 2'd3;

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_OR     = 2'd1;
  localparam logic [1:0] OP_XOR    = 2'd2;
  localparam logic [1:0] OP_AND    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Bit positions inside a record's flag pair.
  localparam int FLAG_START = 0;
  localparam int FLAG_END   = 1;

  typedef logic [NAV_W-1:0] nav_t;

  typedef struct packed {
    logic valid;
    logic peek;
    logic want_end;
  } scan_cmd_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [1:0] flags;
  } scan_res_t;

  typedef enum logic [1:0] {
    UK_WRITE,
    UK_READ,
    UK_RMW
  } user_kind_t;

  typedef struct packed {
    logic       valid;
    user_kind_t kind;
    logic [1:0] op;
  } user_cmd_t;

endpackage
`default_nettype wire

@@ hdl/brtn_req_if.sv @@
// Request channel of the bracket record tree navigator.
// Depends on brtn_pkg for the field widths.
`default_nettype none
interface brtn_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [brtn_pkg::INDEX_W-1:0] index;
  logic                         is_start;
  logic                         is_end;
  logic [brtn_pkg::WORD_W-1:0]  user_value;
  logic [1:0]                   modify_op;
  logic                         want_end;

  modport source (output valid, action, index, is_start, is_end, user_value, modify_op,
                  want_end, input ready);
  modport sink (input valid, action, index, is_start, is_end, user_value, modify_op,
                want_end, output ready);
endinterface
`default_nettype wire

@@ hdl/brtn_rsp_if.sv @@
// Result channel of the bracket record tree navigator.
// Depends on brtn_pkg for the field widths.
`default_nettype none
interface brtn_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [brtn_pkg::NAV_W-1:0] start_index;
  logic signed [brtn_pkg::NAV_W-1:0] end_index;
  logic signed [brtn_pkg::NAV_W-1:0] parent_index;
  logic signed [brtn_pkg::NAV_W-1:0] first_child;
  logic signed [brtn_pkg::NAV_W-1:0] last_child;
  logic signed [brtn_pkg::NAV_W-1:0] next_sibling;
  logic signed [brtn_pkg::NAV_W-1:0] prev_sibling;
  logic [brtn_pkg::WORD_W-1:0]       user_word;

  modport source (output valid, status, start_index, end_index, parent_index, first_child,
                  last_child, next_sibling, prev_sibling, user_word, input ready);
  modport sink (input valid, status, start_index, end_index, parent_index, first_child,
                last_child, next_sibling, prev_sibling, user_word, output ready);
endinterface
`default_nettype wire

@@ hdl/brtn_scan.sv @@
// Flag memory with its depth-counting match scanner and single-entry peek.
// Depends on brtn_pkg for the command and result structs.
`default_nettype none
module brtn_scan #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              we,
  input  wire logic [$clog2(TABLE_DEPTH + 1)-1:0] waddr,
  input  wire logic [1:0]                        wflags,
  input  wire logic [$clog2(TABLE_DEPTH + 1)-1:0] count,
  input  wire brtn_pkg::scan_cmd_t               cmd,
  input  wire logic [$clog2(TABLE_DEPTH + 1)-1:0] cmd_pos,
  output brtn_pkg::scan_res_t                    res,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]     res_pos
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] SC_IDLE  = 2'd0;
  localparam logic [1:0] SC_FIRST = 2'd1;
  localparam logic [1:0] SC_FWD   = 2'd2;
  localparam logic [1:0] SC_BWD   = 2'd3;

  logic [1:0]    flags_mem [TABLE_DEPTH];
  logic [1:0]    rdata;
  logic [1:0]    state, state_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] depth, depth_next, depth_step;
  logic          peek, peek_next, want, want_next;
  logic          done_next, found_next;
  logic [1:0]    flags_next;
  logic [CW-1:0] rpos_next;
  logic          fs, fe, last_fwd;

  always_ff @(posedge clk) begin
    if (we) begin
      flags_mem[waddr[IW-1:0]] <= wflags;
    end
    rdata <= flags_mem[pos_next[IW-1:0]];
  end

  assign fs       = rdata[brtn_pkg::FLAG_START];
  assign fe       = rdata[brtn_pkg::FLAG_END];
  assign last_fwd = (pos + 1'b1) >= count;

  always_comb begin
    if (state == SC_BWD) begin
      depth_step = depth + CW'(fe) - CW'(fs);
    end else begin
      depth_step = depth + CW'(fs) - CW'(fe);
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    depth_next = depth;
    peek_next  = peek;
    want_next  = want;
    done_next  = 1'b0;
    found_next = res.found;
    flags_next = res.flags;
    rpos_next  = res_pos;
    unique case (state)
      SC_IDLE: begin
        if (cmd.valid) begin
          pos_next   = cmd_pos;
          peek_next  = cmd.peek;
          want_next  = cmd.want_end;
          state_next = SC_FIRST;
        end
      end
      SC_FIRST: begin
        flags_next = rdata;
        rpos_next  = pos;
        found_next = 1'b0;
        if (peek) begin
          found_next = 1'b1;
          done_next  = 1'b1;
        end else if (fs) begin
          // A record flagged both ways closes itself.
          if (!want || fe) begin
            found_next = 1'b1;
            done_next  = 1'b1;
          end else if (last_fwd) begin
            done_next = 1'b1;
          end else begin
            depth_next = CW'(1);
            pos_next   = pos + 1'b1;
            state_next = SC_FWD;
          end
        end else if (fe) begin
          if (want) begin
            found_next = 1'b1;
            done_next  = 1'b1;
          end else if (pos == '0) begin
            done_next = 1'b1;
          end else begin
            depth_next = CW'(1);
            pos_next   = pos - 1'b1;
            state_next = SC_BWD;
          end
        end else begin
          done_next = 1'b1;
        end
        if (done_next) begin
          state_next = SC_IDLE;
        end
      end
      SC_FWD: begin
        rpos_next  = pos;
        depth_next = depth_step;
        if (depth_step == '0) begin
          found_next = 1'b1;
          done_next  = 1'b1;
          state_next = SC_IDLE;
        end else if (last_fwd) begin
          done_next  = 1'b1;
          state_next = SC_IDLE;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      SC_BWD: begin
        rpos_next  = pos;
        depth_next = depth_step;
        if (depth_step == '0) begin
          found_next = 1'b1;
          done_next  = 1'b1;
          state_next = SC_IDLE;
        end else if (pos == '0) begin
          done_next  = 1'b1;
          state_next = SC_IDLE;
        end else begin
          pos_next = pos - 1'b1;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SC_IDLE;
      res.done <= 1'b0;
    end else begin
      state    <= state_next;
      res.done <= done_next;
    end
    pos       <= pos_next;
    depth     <= depth_next;
    peek      <= peek_next;
    want      <= want_next;
    res.found <= found_next;
    res.flags <= flags_next;
    res_pos   <= rpos_next;
  end

endmodule
`default_nettype wire

@@ hdl/brtn_user.sv @@
// User word memory with write, read and read-modify-write commands.
// Depends on brtn_pkg for the command struct and operation codes.
`default_nettype none
module brtn_user #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire brtn_pkg::user_cmd_t                cmd,
  input  wire logic [$clog2(TABLE_DEPTH + 1)-1:0] addr,
  input  wire logic [brtn_pkg::WORD_W-1:0]        value,
  output logic                                    done,
  output logic [brtn_pkg::WORD_W-1:0]             word
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [brtn_pkg::WORD_W-1:0] user_mem [TABLE_DEPTH];
  logic [brtn_pkg::WORD_W-1:0] rdata, alu, pval, wd;
  logic                        pend;
  logic                        prmw;
  logic [1:0]                  pop;
  logic [CW-1:0]               paddr, wa;
  logic                        wen;

  always_comb begin
    case (pop)
      brtn_pkg::OP_OR:  alu = rdata | pval;
      brtn_pkg::OP_XOR: alu = rdata ^ pval;
      brtn_pkg::OP_AND: alu = rdata & pval;
      default:          alu = pval;
    endcase
  end

  // The write-back of a read-modify-write and a plain write never meet.
  assign wen = (pend && prmw) || (cmd.valid && cmd.kind == brtn_pkg::UK_WRITE);
  assign wa  = pend ? paddr : addr;
  assign wd  = pend ? alu : value;

  always_ff @(posedge clk) begin
    if (wen) begin
      user_mem[wa[IW-1:0]] <= wd;
    end
    rdata <= user_mem[addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= cmd.valid && cmd.kind != brtn_pkg::UK_WRITE;
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      prmw  <= cmd.kind == brtn_pkg::UK_RMW;
      pop   <= cmd.op;
      paddr <= addr;
      pval  <= value;
    end
    if (pend) begin
      word <= prmw ? alu : rdata;
    end
  end

endmodule
`default_nettype wire

@@ hdl/bracket_record_tree_navigator.sv @@
// Top level of the bracket record tree navigator: sequencer and result register.
// Depends on brtn_pkg, brtn_req_if, brtn_rsp_if, brtn_scan and brtn_user.
`default_nettype none
// The block keeps a table of up to TABLE_DEPTH parse records, each holding a
// start flag, an end flag and a 32-bit user word, and answers one result for
// every request. Clear and append go straight to the final step, which loads
// their result into the output register once that register is free; the
// block then returns to idle. A query and a modify are worked out by a
// sequencer that issues depth-counting scans over the flag memory; that
// memory has one read port, so a scan handles one record per cycle. A modify
// runs a start scan, an end scan and a read-modify-write at the start and at
// the end. A query runs the start and end scans, the parent walk with its
// final scan, and for each hop a peek and, as needed, a leave scan, an entry
// peek and an entry scan. The parent walk steps across the siblings that
// follow the record, end record to end record, peeking at each. Requests are
// taken only while the sequencer is idle; a finished result sits in the
// output register until it is taken, and the next request may be accepted
// meanwhile. No clearing pass is needed after reset: only records below the
// fill count are ever read, and every one of them was written by an append.
module bracket_record_tree_navigator #(
  parameter int TABLE_DEPTH = 1024
) (
  input wire logic   clk,
  input wire logic   rst,
  brtn_req_if.sink   req,
  brtn_rsp_if.source rsp
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (CW > brtn_pkg::INDEX_W) ? CW : brtn_pkg::INDEX_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_Q_START = 5'd1;
  localparam logic [4:0] S_Q_END   = 5'd2;
  localparam logic [4:0] S_P_MATCH = 5'd3;
  localparam logic [4:0] S_P_PEEK  = 5'd4;
  localparam logic [4:0] S_P_TAIL  = 5'd5;
  localparam logic [4:0] S_P_FINAL = 5'd6;
  localparam logic [4:0] S_H_BEGIN = 5'd7;
  localparam logic [4:0] S_H_PEEK  = 5'd8;
  localparam logic [4:0] S_H_LEAVE = 5'd9;
  localparam logic [4:0] S_H_STEP  = 5'd10;
  localparam logic [4:0] S_H_EPEEK = 5'd11;
  localparam logic [4:0] S_H_ENTER = 5'd12;
  localparam logic [4:0] S_H_NEXT  = 5'd13;
  localparam logic [4:0] S_U_READ  = 5'd14;
  localparam logic [4:0] S_M_START = 5'd15;
  localparam logic [4:0] S_M_END   = 5'd16;
  localparam logic [4:0] S_M_RMW_S = 5'd17;
  localparam logic [4:0] S_M_RMW_E = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  logic [4:0]                  state;
  logic [CW-1:0]               count;
  logic [CW-1:0]               idx_pos;
  logic                        want;
  logic [1:0]                  op;
  logic [brtn_pkg::WORD_W-1:0] value;
  logic [1:0]                  status;
  logic [brtn_pkg::WORD_W-1:0] word;

  // Result slots in output order: start, end, parent, first child, last
  // child, next sibling, previous sibling.
  logic [6:0]    res_found;
  logic [CW-1:0] res_pos [7];

  logic          last_found;
  logic [CW-1:0] last;
  logic [1:0]    hsel;
  logic [CW-1:0] hop_r;

  brtn_pkg::scan_cmd_t scan_cmd;
  logic [CW-1:0]       scan_pos;
  brtn_pkg::scan_res_t scan_res;
  logic [CW-1:0]       scan_rpos;

  brtn_pkg::user_cmd_t         user_cmd;
  logic [CW-1:0]               user_addr;
  logic                        user_done;
  logic [brtn_pkg::WORD_W-1:0] user_word;

  logic          flag_we;
  logic [CW-1:0] flag_waddr;
  logic [1:0]    flag_wdata;

  logic          accept, in_range;
  logic          hop_fwd, leave_end, enter_ok;
  logic [CW-1:0] enter_pos, tail_pos;
  logic [2:0]    hop_slot;

  function automatic brtn_pkg::nav_t to_nav(input logic f, input logic [CW-1:0] p);
    to_nav = f ? brtn_pkg::nav_t'(p) : '1;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = PW'(req.index) < PW'(count);

  // Hop selection: 0 first child, 1 last child, 2 next sibling, 3 previous
  // sibling. Inner forward and outer backward leave a node through its start.
  assign hop_fwd   = !hsel[0];
  assign leave_end = (hop_fwd == !hsel[1]);
  assign hop_slot  = {1'b0, hsel} + 3'd3;
  assign enter_ok  = hop_fwd ? ((hop_r + 1'b1) < count) : (hop_r != '0);
  assign enter_pos = hop_fwd ? (hop_r + 1'b1) : (hop_r - 1'b1);
  // The parent sits right after the last end reached by the sibling walk.
  assign tail_pos  = last_found ? (last + 1'b1) : '0;

  brtn_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .we      (flag_we),
    .waddr   (flag_waddr),
    .wflags  (flag_wdata),
    .count   (count),
    .cmd     (scan_cmd),
    .cmd_pos (scan_pos),
    .res     (scan_res),
    .res_pos (scan_rpos)
  );

  brtn_user #(.TABLE_DEPTH(TABLE_DEPTH)) u_user (
    .clk   (clk),
    .rst   (rst),
    .cmd   (user_cmd),
    .addr  (user_addr),
    .value (value),
    .done  (user_done),
    .word  (user_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      scan_cmd.valid <= 1'b0;
      user_cmd.valid <= 1'b0;
      flag_we        <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      scan_cmd.valid <= 1'b0;
      user_cmd.valid <= 1'b0;
      flag_we        <= 1'b0;
      // In the final step the output register is reloaded instead.
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx_pos    <= CW'(req.index);
            want       <= req.want_end;
            op         <= req.modify_op;
            value      <= req.user_value;
            status     <= brtn_pkg::ST_OK;
            word       <= '0;
            res_found  <= '0;
            last_found <= 1'b0;
            hsel       <= 2'd0;
            state      <= S_FIN;
            case (req.action)
              brtn_pkg::ACT_CLEAR: begin
                count <= '0;
              end
              brtn_pkg::ACT_APPEND: begin
                if (count == CW'(TABLE_DEPTH)) begin
                  status <= brtn_pkg::ST_FULL;
                end else begin
                  flag_we    <= 1'b1;
                  flag_waddr <= count;
                  flag_wdata <= {req.is_end, req.is_start};
                  user_cmd   <= '{valid: 1'b1, kind: brtn_pkg::UK_WRITE, op: req.modify_op};
                  user_addr  <= count;
                  count      <= count + 1'b1;
                end
              end
              default: begin
                if (!in_range) begin
                  status <= brtn_pkg::ST_BAD;
                end else begin
                  scan_cmd <= '{valid: 1'b1, peek: 1'b0, want_end: 1'b0};
                  scan_pos <= CW'(req.index);
                  state    <= (req.action == brtn_pkg::ACT_QUERY) ? S_Q_START : S_M_START;
                end
              end
            endcase
          end
        end
        S_Q_START: begin
          if (scan_res.done) begin
            res_found[0] <= scan_res.found;
            res_pos[0]   <= scan_rpos;
            scan_cmd     <= '{valid: 1'b1, peek: 1'b0, want_end: 1'b1};
            scan_pos     <= idx_pos;
            state        <= S_Q_END;
          end
        end
        S_Q_END: begin
          if (scan_res.done) begin
            res_found[1] <= scan_res.found;
            res_pos[1]   <= scan_rpos;
            scan_cmd     <= '{valid: 1'b1, peek: 1'b0, want_end: 1'b1};
            scan_pos     <= idx_pos;
            state        <= S_P_MATCH;
          end
        end
        S_P_MATCH: begin
          // Walk forward over siblings, end record to end record.
          if (scan_res.done) begin
            if (!scan_res.found) begin
              state <= S_P_TAIL;
            end else begin
              last_found <= 1'b1;
              last       <= scan_rpos;
              if ((scan_rpos + 1'b1) >= count) begin
                state <= S_P_TAIL;
              end else begin
                scan_cmd <= '{valid: 1'b1, peek: 1'b1, want_end: 1'b0};
                scan_pos <= scan_rpos + 1'b1;
                state    <= S_P_PEEK;
              end
            end
          end
        end
        S_P_PEEK: begin
          if (scan_res.done) begin
            if (scan_res.flags[brtn_pkg::FLAG_START]) begin
              scan_cmd <= '{valid: 1'b1, peek: 1'b0, want_end: 1'b1};
              scan_pos <= scan_rpos;
              state    <= S_P_MATCH;
            end else begin
              state <= S_P_TAIL;
            end
          end
        end
        S_P_TAIL: begin
          if (tail_pos < count) begin
            scan_cmd <= '{valid: 1'b1, peek: 1'b0, want_end: want};
            scan_pos <= tail_pos;
            state    <= S_P_FINAL;
          end else begin
            state <= S_H_BEGIN;
          end
        end
        S_P_FINAL: begin
          if (scan_res.done) begin
            res_found[2] <= scan_res.found;
            res_pos[2]   <= scan_rpos;
            state        <= S_H_BEGIN;
          end
        end
        S_H_BEGIN: begin
          scan_cmd <= '{valid: 1'b1, peek: 1'b1, want_end: 1'b0};
          scan_pos <= idx_pos;
          state    <= S_H_PEEK;
        end
        S_H_PEEK: begin
          if (scan_res.done) begin
            if (scan_res.flags[leave_end ? brtn_pkg::FLAG_END : brtn_pkg::FLAG_START]) begin
              scan_cmd <= '{valid: 1'b1, peek: 1'b0, want_end: !leave_end};
              scan_pos <= idx_pos;
              state    <= S_H_LEAVE;
            end else begin
              hop_r <= idx_pos;
              state <= S_H_STEP;
            end
          end
        end
        S_H_LEAVE: begin
          if (scan_res.done) begin
            hop_r <= scan_rpos;
            state <= scan_res.found ? S_H_STEP : S_H_NEXT;
          end
        end
        S_H_STEP: begin
          if (enter_ok) begin
            scan_cmd <= '{valid: 1'b1, peek: 1'b1, want_end: 1'b0};
            scan_pos <= enter_pos;
            state    <= S_H_EPEEK;
          end else begin
            state <= S_H_NEXT;
          end
        end
        S_H_EPEEK: begin
          if (scan_res.done) begin
            if (scan_res.flags[hop_fwd ? brtn_pkg::FLAG_START : brtn_pkg::FLAG_END]) begin
              scan_cmd <= '{valid: 1'b1, peek: 1'b0, want_end: want};
              scan_pos <= scan_rpos;
              state    <= S_H_ENTER;
            end else begin
              state <= S_H_NEXT;
            end
          end
        end
        S_H_ENTER: begin
          if (scan_res.done) begin
            res_found[hop_slot] <= scan_res.found;
            res_pos[hop_slot]   <= scan_rpos;
            state               <= S_H_NEXT;
          end
        end
        S_H_NEXT: begin
          if (hsel != 2'd3) begin
            hsel  <= hsel + 2'd1;
            state <= S_H_BEGIN;
          end else if (res_found[0]) begin
            user_cmd  <= '{valid: 1'b1, kind: brtn_pkg::UK_READ, op: op};
            user_addr <= res_pos[0];
            state     <= S_U_READ;
          end else begin
            status <= brtn_pkg::ST_BAD;
            state  <= S_FIN;
          end
        end
        S_U_READ: begin
          if (user_done) begin
            word  <= user_word;
            state <= S_FIN;
          end
        end
        S_M_START: begin
          if (scan_res.done) begin
            if (!scan_res.found) begin
              status <= brtn_pkg::ST_BAD;
              state  <= S_FIN;
            end else begin
              res_pos[0] <= scan_rpos;
              scan_cmd   <= '{valid: 1'b1, peek: 1'b0, want_end: 1'b1};
              scan_pos   <= scan_rpos;
              state      <= S_M_END;
            end
          end
        end
        S_M_END: begin
          if (scan_res.done) begin
            if (!scan_res.found) begin
              status <= brtn_pkg::ST_BAD;
              state  <= S_FIN;
            end else begin
              res_found[1:0] <= 2'b11;
              res_pos[1]     <= scan_rpos;
              user_cmd       <= '{valid: 1'b1, kind: brtn_pkg::UK_RMW, op: op};
              user_addr      <= res_pos[0];
              state          <= S_M_RMW_S;
            end
          end
        end
        S_M_RMW_S: begin
          if (user_done) begin
            word      <= user_word;
            user_cmd  <= '{valid: 1'b1, kind: brtn_pkg::UK_RMW, op: op};
            user_addr <= res_pos[1];
            state     <= S_M_RMW_E;
          end
        end
        S_M_RMW_E: begin
          // A record that is its own start and end takes the op twice.
          if (user_done) begin
            if (res_pos[0] == res_pos[1]) begin
              word <= user_word;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status;
            rsp.start_index  <= to_nav(res_found[0], res_pos[0]);
            rsp.end_index    <= to_nav(res_found[1], res_pos[1]);
            rsp.parent_index <= to_nav(res_found[2], res_pos[2]);
            rsp.first_child  <= to_nav(res_found[3], res_pos[3]);
            rsp.last_child   <= to_nav(res_found[4], res_pos[4]);
            rsp.next_sibling <= to_nav(res_found[5], res_pos[5]);
            rsp.prev_sibling <= to_nav(res_found[6], res_pos[6]);
            rsp.user_word    <= word;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == brtn_pkg::ACT_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == brtn_pkg::ACT_APPEND && count != CW'(TABLE_DEPTH))
    |=> (count == CW'($past(count) + 1'b1)))
    else $error("append did not advance the record count");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(scan_cmd.valid && user_cmd.valid))
    else $error("scanner and user memory started together");

  a_scan_owned: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state != S_IDLE && state != S_FIN))
    else $error("scan finished with no step waiting for it");
`endif

endmodule
`default_nettype wire
